// File: rtl/core/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared widths, codes and types of the linear-probe hash table core.
// ----------------------------------------------------------------------------
`default_nettype none
package lpht_pkg;

	localparam int SLOTS  = 64;
	localparam int SLOT_W = 6;
	localparam int LINK_W = 7;
	localparam int KEY_W  = 32;
	localparam int LEN_W  = 7;
	localparam int CNT_W  = 7;
	localparam int BIT_W  = 5;

	localparam logic [LINK_W-1:0] LINK_NIL = LINK_W'(SLOTS);
	localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(SLOTS);

	localparam logic [2:0] CMD_INSERT      = 3'd0;
	localparam logic [2:0] CMD_FIND        = 3'd1;
	localparam logic [2:0] CMD_REMOVE_KEY  = 3'd2;
	localparam logic [2:0] CMD_REMOVE_SLOT = 3'd3;
	localparam logic [2:0] CMD_CLEAR       = 3'd4;

	localparam logic [2:0] STS_OK          = 3'd0;
	localparam logic [2:0] STS_DUPLICATE   = 3'd1;
	localparam logic [2:0] STS_FULL        = 3'd2;
	localparam logic [2:0] STS_MISS_EMPTY  = 3'd3;
	localparam logic [2:0] STS_SLOT_UNUSED = 3'd4;
	localparam logic [2:0] STS_MISS_FULL   = 3'd5;

	localparam logic [1:0] ST_EMPTY = 2'd0;
	localparam logic [1:0] ST_USED  = 2'd1;
	localparam logic [1:0] ST_TOMB  = 2'd2;

	typedef struct packed {
		logic [2:0]        command;
		logic [KEY_W-1:0]  key;
		logic [SLOT_W-1:0] slot;
	} request_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [SLOT_W-1:0] slot_index;
		logic [CNT_W-1:0]  item_count;
		logic [SLOT_W-1:0] oldest_slot;
		logic [SLOT_W-1:0] newest_slot;
		logic              list_empty;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MOD,
		S_PROBE_RD,
		S_PROBE_CHK,
		S_RESOLVE,
		S_SLOT_RD,
		S_CHECK,
		S_LINK_A,
		S_LINK_B,
		S_UNLINK_RD,
		S_UNLINK_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic       capture;
		logic       clear_all;
		logic       mod_step;
		logic       probe_rd;
		logic       probe_chk;
		logic       link_a;
		logic       link_b;
		logic       unlink_rd;
		logic       unlink_wr;
		logic       set_status;
		logic [2:0] code;
		logic       take_found;
		logic       result;
	} ctl_t;

	typedef struct packed {
		logic       mod_last;
		logic       probe_end;
		logic [2:0] probe_code;
		logic       free_valid;
		logic       slot_ok;
		logic [2:0] cmd;
	} dp_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/linear_probe_hash_table_with_age_list_core.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_with_age_list_core
// Open-addressing hash table with linear probing, tombstones and an
// insertion-order list reporting the oldest and newest entries.
//
//   Channel   Handshake             Payload
//   request   start & !busy         request_t: command, key, slot
//   result    done (one cycle)      result_t: status, slot_index, item_count,
//                                   oldest_slot, newest_slot, list_empty
//   config    cfg_we                cfg_wdata: table length
//
// Find, insert and remove by key reduce the key modulo the length bit-serially,
// then probe slots from that index (1 up to the length); a stored insert or a
// removed key adds the age-list link or unlink steps. Remove by slot checks the
// slot and unlinks it unless refused; clear and unused codes go straight to done.
// Reset leaves the table empty with length 64; a length write also clears it.
// busy stays high through the one-cycle strobe, which cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module linear_probe_hash_table_with_age_list_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire lpht_pkg::request_t request,
	output logic                    busy,
	input  wire logic               cfg_we,
	input  wire logic [6:0]         cfg_wdata,
	output logic                    done,
	output lpht_pkg::result_t       result
);

	lpht_pkg::ctl_t    ctl;
	lpht_pkg::dp_sts_t sts;

	lpht_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (request.command),
		.sts     (sts),
		.ctl     (ctl),
		.busy    (busy)
	);

	lpht_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ctl       (ctl),
		.sts       (sts),
		.result    (result)
	);

	assign done = ctl.result;

endmodule
`default_nettype wire

// File: rtl/core/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module lpht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/core/lpht_ctrl.sv
// ----------------------------------------------------------------------------
// lpht_ctrl
// Command sequencer: hashing, probe loop, age-list link and unlink steps.
// ----------------------------------------------------------------------------
`default_nettype none
module lpht_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [2:0]       command,
	input  wire lpht_pkg::dp_sts_t sts,
	output lpht_pkg::ctl_t        ctl,
	output logic                  busy
);

	lpht_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpht_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		busy    = (state_q != lpht_pkg::S_IDLE);
		case (state_q)
			lpht_pkg::S_IDLE: begin
				if (start) begin
					ctl.capture = 1'b1;
					case (command)
						lpht_pkg::CMD_INSERT,
						lpht_pkg::CMD_FIND,
						lpht_pkg::CMD_REMOVE_KEY: state_d = lpht_pkg::S_MOD;
						lpht_pkg::CMD_REMOVE_SLOT: state_d = lpht_pkg::S_SLOT_RD;
						lpht_pkg::CMD_CLEAR: begin
							ctl.clear_all = 1'b1;
							state_d       = lpht_pkg::S_DONE;
						end
						default: state_d = lpht_pkg::S_DONE;
					endcase
				end
			end
			lpht_pkg::S_MOD: begin
				ctl.mod_step = 1'b1;
				if (sts.mod_last) begin
					state_d = lpht_pkg::S_PROBE_RD;
				end
			end
			lpht_pkg::S_PROBE_RD: begin
				ctl.probe_rd = 1'b1;
				state_d      = lpht_pkg::S_PROBE_CHK;
			end
			lpht_pkg::S_PROBE_CHK: begin
				ctl.probe_chk = 1'b1;
				state_d = sts.probe_end ? lpht_pkg::S_RESOLVE : lpht_pkg::S_PROBE_RD;
			end
			lpht_pkg::S_RESOLVE: begin
				state_d = lpht_pkg::S_DONE;
				case (sts.cmd)
					lpht_pkg::CMD_INSERT: begin
						if (sts.probe_code == lpht_pkg::STS_OK) begin
							ctl.set_status = 1'b1;
							ctl.code       = lpht_pkg::STS_DUPLICATE;
						end else if (!sts.free_valid) begin
							ctl.set_status = 1'b1;
							ctl.code       = lpht_pkg::STS_FULL;
						end else begin
							state_d = lpht_pkg::S_LINK_A;
						end
					end
					lpht_pkg::CMD_REMOVE_KEY: begin
						if (sts.probe_code == lpht_pkg::STS_OK) begin
							state_d = lpht_pkg::S_UNLINK_RD;
						end else begin
							ctl.set_status = 1'b1;
							ctl.code       = sts.probe_code;
						end
					end
					default: begin
						ctl.set_status = 1'b1;
						ctl.code       = sts.probe_code;
						ctl.take_found = (sts.probe_code == lpht_pkg::STS_OK);
					end
				endcase
			end
			// The slot status RAM has registered read data, so this state waits for the addressed entry.
			lpht_pkg::S_SLOT_RD: begin
				state_d = lpht_pkg::S_CHECK;
			end
			lpht_pkg::S_CHECK: begin
				if (sts.slot_ok) begin
					state_d = lpht_pkg::S_UNLINK_RD;
				end else begin
					ctl.set_status = 1'b1;
					ctl.code       = lpht_pkg::STS_SLOT_UNUSED;
					state_d        = lpht_pkg::S_DONE;
				end
			end
			lpht_pkg::S_LINK_A: begin
				ctl.link_a = 1'b1;
				state_d    = lpht_pkg::S_LINK_B;
			end
			lpht_pkg::S_LINK_B: begin
				ctl.link_b = 1'b1;
				state_d    = lpht_pkg::S_DONE;
			end
			lpht_pkg::S_UNLINK_RD: begin
				ctl.unlink_rd = 1'b1;
				state_d       = lpht_pkg::S_UNLINK_WR;
			end
			lpht_pkg::S_UNLINK_WR: begin
				ctl.unlink_wr = 1'b1;
				state_d       = lpht_pkg::S_DONE;
			end
			lpht_pkg::S_DONE: begin
				ctl.result = 1'b1;
				state_d    = lpht_pkg::S_IDLE;
			end
			default: state_d = lpht_pkg::S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/core/lpht_datapath.sv
// ----------------------------------------------------------------------------
// lpht_datapath
// Slot state, key and link memories, modulo unit, probe registers and result.
// ----------------------------------------------------------------------------
`default_nettype none
module lpht_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire lpht_pkg::request_t  request,
	input  wire logic                cfg_we,
	input  wire logic [6:0]          cfg_wdata,
	input  wire lpht_pkg::ctl_t      ctl,
	output lpht_pkg::dp_sts_t        sts,
	output lpht_pkg::result_t        result
);

	logic [2:0]                  cmd_q;
	logic [lpht_pkg::KEY_W-1:0]  key_q;
	logic [lpht_pkg::KEY_W-1:0]  mod_sh_q;
	logic [lpht_pkg::SLOT_W-1:0] slot_q;
	logic [lpht_pkg::LEN_W-1:0]  len_q;
	logic [lpht_pkg::SLOT_W-1:0] rem_q;
	logic [lpht_pkg::BIT_W-1:0]  bit_q;
	logic [lpht_pkg::SLOT_W-1:0] idx_q;
	logic [lpht_pkg::LEN_W-1:0]  n_q;
	logic [lpht_pkg::LINK_W-1:0] free_q;
	logic [lpht_pkg::SLOT_W-1:0] at_q;
	logic [2:0]                  code_q;
	logic [lpht_pkg::SLOTS-1:0]  stat_valid_q;
	logic [lpht_pkg::LINK_W-1:0] newest_q;
	logic [lpht_pkg::LINK_W-1:0] oldest_q;
	logic [lpht_pkg::CNT_W-1:0]  cnt_q;
	logic [2:0]                  res_status_q;
	logic [lpht_pkg::SLOT_W-1:0] sidx_q;

	logic [lpht_pkg::LEN_W-1:0]  len_new;
	logic [lpht_pkg::LEN_W-1:0]  mod_sh;
	logic [lpht_pkg::LEN_W-1:0]  mod_sub;
	logic [lpht_pkg::SLOT_W-1:0] rem_next;
	logic [lpht_pkg::SLOT_W-1:0] stat_raddr;
	logic [1:0]                  stat_rdata;
	logic                        stat_we;
	logic [1:0]                  stat_wdata;
	logic [1:0]                  st_probe;
	logic [lpht_pkg::KEY_W-1:0]  key_rdata;
	logic                        hit;
	logic [lpht_pkg::LINK_W-1:0] free_next;
	logic [lpht_pkg::LEN_W-1:0]  idx_inc;
	logic [lpht_pkg::SLOT_W-1:0] idx_next;
	logic [lpht_pkg::SLOT_W-1:0] target;
	logic [lpht_pkg::LINK_W-1:0] older_rdata;
	logic [lpht_pkg::LINK_W-1:0] newer_rdata;
	logic                        key_we;
	logic                        older_we;
	logic [lpht_pkg::SLOT_W-1:0] older_waddr;
	logic [lpht_pkg::LINK_W-1:0] older_wdata;
	logic                        newer_we;
	logic [lpht_pkg::SLOT_W-1:0] newer_waddr;
	logic [lpht_pkg::LINK_W-1:0] newer_wdata;
	logic                        list_empty;

	// A written length of zero acts as one; anything past the table size saturates.
	always_comb begin
		if (cfg_wdata == '0) begin
			len_new = lpht_pkg::LEN_W'(1);
		end else if (cfg_wdata > lpht_pkg::LEN_MAX) begin
			len_new = lpht_pkg::LEN_MAX;
		end else begin
			len_new = cfg_wdata;
		end
	end

	// Restoring remainder, one key bit per cycle, most significant first.
	assign mod_sh   = {rem_q, mod_sh_q[lpht_pkg::KEY_W-1]};
	assign mod_sub  = mod_sh - len_q;
	assign rem_next = (mod_sh >= len_q) ? mod_sub[lpht_pkg::SLOT_W-1:0]
	                                    : mod_sh[lpht_pkg::SLOT_W-1:0];

	// Slot status lives in a RAM; a slot not written since the last clear
	// reads as empty through its valid bit.
	assign stat_raddr = (cmd_q == lpht_pkg::CMD_REMOVE_SLOT) ? slot_q : idx_q;
	assign st_probe   = stat_valid_q[stat_raddr] ? stat_rdata : lpht_pkg::ST_EMPTY;
	assign stat_we    = ctl.link_a || ctl.unlink_wr;
	assign stat_wdata = ctl.link_a ? lpht_pkg::ST_USED : lpht_pkg::ST_TOMB;

	assign hit       = (st_probe == lpht_pkg::ST_USED) && (key_rdata == key_q);
	assign free_next = ((st_probe != lpht_pkg::ST_USED) && free_q[lpht_pkg::LINK_W-1])
	                   ? {1'b0, idx_q} : free_q;
	assign idx_inc   = {1'b0, idx_q} + lpht_pkg::LEN_W'(1);
	assign idx_next  = (idx_inc >= len_q) ? '0 : idx_inc[lpht_pkg::SLOT_W-1:0];

	always_comb begin
		case (cmd_q)
			lpht_pkg::CMD_REMOVE_SLOT: target = slot_q;
			lpht_pkg::CMD_INSERT:      target = free_q[lpht_pkg::SLOT_W-1:0];
			default:                   target = at_q;
		endcase
	end

	always_comb begin
		sts.mod_last   = (bit_q == lpht_pkg::BIT_W'(lpht_pkg::KEY_W - 1));
		sts.probe_end  = (st_probe == lpht_pkg::ST_EMPTY) || hit
		                 || (n_q == len_q - lpht_pkg::LEN_W'(1));
		sts.probe_code = code_q;
		sts.free_valid = !free_q[lpht_pkg::LINK_W-1];
		sts.slot_ok    = ({1'b0, slot_q} < len_q) && (st_probe == lpht_pkg::ST_USED);
		sts.cmd        = cmd_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q    <= request.command;
			key_q    <= request.key;
			mod_sh_q <= request.key;
			slot_q   <= request.slot;
			rem_q    <= '0;
			bit_q    <= '0;
			sidx_q   <= '0;
			res_status_q <= lpht_pkg::STS_OK;
		end
		if (ctl.mod_step) begin
			rem_q    <= rem_next;
			bit_q    <= bit_q + lpht_pkg::BIT_W'(1);
			mod_sh_q <= {mod_sh_q[lpht_pkg::KEY_W-2:0], 1'b0};
			if (sts.mod_last) begin
				idx_q  <= rem_next;
				n_q    <= '0;
				free_q <= lpht_pkg::LINK_NIL;
			end
		end
		if (ctl.probe_chk) begin
			free_q <= free_next;
			idx_q  <= idx_next;
			n_q    <= n_q + lpht_pkg::LEN_W'(1);
			if (hit) begin
				at_q   <= idx_q;
				code_q <= lpht_pkg::STS_OK;
			end else if (st_probe == lpht_pkg::ST_EMPTY) begin
				code_q <= lpht_pkg::STS_MISS_EMPTY;
			end else begin
				code_q <= lpht_pkg::STS_MISS_FULL;
			end
		end
		if (ctl.set_status) begin
			res_status_q <= ctl.code;
		end
		if (ctl.take_found) begin
			sidx_q <= at_q;
		end
		if (ctl.link_a || ctl.unlink_wr) begin
			sidx_q <= target;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q        <= lpht_pkg::LEN_MAX;
			newest_q     <= lpht_pkg::LINK_NIL;
			oldest_q     <= lpht_pkg::LINK_NIL;
			cnt_q        <= '0;
			stat_valid_q <= '0;
		end else begin
			if (cfg_we) begin
				len_q <= len_new;
			end
			if (cfg_we || ctl.clear_all) begin
				newest_q     <= lpht_pkg::LINK_NIL;
				oldest_q     <= lpht_pkg::LINK_NIL;
				cnt_q        <= '0;
				stat_valid_q <= '0;
			end else begin
				if (ctl.link_a) begin
					stat_valid_q[target] <= 1'b1;
				end
				if (ctl.link_b) begin
					newest_q <= {1'b0, target};
					if (oldest_q[lpht_pkg::LINK_W-1]) begin
						oldest_q <= {1'b0, target};
					end
					cnt_q <= cnt_q + lpht_pkg::CNT_W'(1);
				end
				if (ctl.unlink_wr) begin
					stat_valid_q[target] <= 1'b1;
					if (older_rdata[lpht_pkg::LINK_W-1]) begin
						oldest_q <= newer_rdata;
					end
					if (newer_rdata[lpht_pkg::LINK_W-1]) begin
						newest_q <= older_rdata;
					end
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - lpht_pkg::CNT_W'(1);
					end
				end
			end
		end
	end

	// Link memory traffic. Linking is split over S_LINK_A and S_LINK_B because the newer-link RAM
	// must first clear the new slot's entry and then point the old newest at it.
	assign key_we = ctl.link_a;

	always_comb begin
		older_we    = 1'b0;
		older_waddr = target;
		older_wdata = newest_q;
		newer_we    = 1'b0;
		newer_waddr = target;
		newer_wdata = lpht_pkg::LINK_NIL;
		if (ctl.link_a) begin
			older_we = 1'b1;
			newer_we = 1'b1;
		end else if (ctl.link_b) begin
			newer_we    = !newest_q[lpht_pkg::LINK_W-1];
			newer_waddr = newest_q[lpht_pkg::SLOT_W-1:0];
			newer_wdata = {1'b0, target};
		end else if (ctl.unlink_wr) begin
			newer_we    = !older_rdata[lpht_pkg::LINK_W-1];
			newer_waddr = older_rdata[lpht_pkg::SLOT_W-1:0];
			newer_wdata = newer_rdata;
			older_we    = !newer_rdata[lpht_pkg::LINK_W-1];
			older_waddr = newer_rdata[lpht_pkg::SLOT_W-1:0];
			older_wdata = older_rdata;
		end
	end

	lpht_ram #(.WIDTH(2), .DEPTH(lpht_pkg::SLOTS)) u_stat_ram (
		.clk   (clk),
		.we    (stat_we),
		.waddr (target),
		.wdata (stat_wdata),
		.raddr (stat_raddr),
		.rdata (stat_rdata)
	);

	lpht_ram #(.WIDTH(lpht_pkg::KEY_W), .DEPTH(lpht_pkg::SLOTS)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (target),
		.wdata (key_q),
		.raddr (idx_q),
		.rdata (key_rdata)
	);

	lpht_ram #(.WIDTH(lpht_pkg::LINK_W), .DEPTH(lpht_pkg::SLOTS)) u_older_ram (
		.clk   (clk),
		.we    (older_we),
		.waddr (older_waddr),
		.wdata (older_wdata),
		.raddr (target),
		.rdata (older_rdata)
	);

	lpht_ram #(.WIDTH(lpht_pkg::LINK_W), .DEPTH(lpht_pkg::SLOTS)) u_newer_ram (
		.clk   (clk),
		.we    (newer_we),
		.waddr (newer_waddr),
		.wdata (newer_wdata),
		.raddr (target),
		.rdata (newer_rdata)
	);

	assign list_empty = (cnt_q == '0);

	always_comb begin
		result.status      = res_status_q;
		result.slot_index  = sidx_q;
		result.item_count  = cnt_q;
		result.oldest_slot = list_empty ? '0 : oldest_q[lpht_pkg::SLOT_W-1:0];
		result.newest_slot = list_empty ? '0 : newest_q[lpht_pkg::SLOT_W-1:0];
		result.list_empty  = list_empty;
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= lpht_pkg::CNT_W'(lpht_pkg::SLOTS))
		else $error("entry count above table size");
	a_newest_null: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) == newest_q[lpht_pkg::LINK_W-1])
		else $error("newest pointer disagrees with entry count");
	a_oldest_null: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) == oldest_q[lpht_pkg::LINK_W-1])
		else $error("oldest pointer disagrees with entry count");
	a_link_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.link_b && !cfg_we |=> cnt_q == $past(cnt_q) + lpht_pkg::CNT_W'(1))
		else $error("insert did not grow the entry count");
`endif

endmodule
`default_nettype wire
